/* src/rhcc_pkg.sv */
// ----------------------------------------------------------------------------
// rhcc_pkg
// Types and constants shared by the RGB565 HSL color classifier.
// ----------------------------------------------------------------------------
package rhcc_pkg;

	localparam int NUM_STAGES = 8;

	// register indexes on the configuration channel
	localparam logic [2:0] REG_DARK_LIMIT   = 3'd0;
	localparam logic [2:0] REG_BRIGHT_LIMIT = 3'd1;
	localparam logic [2:0] REG_GRAY_LIMIT   = 3'd2;
	localparam logic [2:0] REG_YELLOW_START = 3'd3;
	localparam logic [2:0] REG_GREEN_START  = 3'd4;
	localparam logic [2:0] REG_GREEN_END    = 3'd5;
	localparam logic [2:0] REG_BLUE_START   = 3'd6;
	localparam logic [2:0] REG_BLUE_END     = 3'd7;

	localparam logic [7:0] RST_DARK_LIMIT   = 8'd45;
	localparam logic [7:0] RST_BRIGHT_LIMIT = 8'd120;
	localparam logic [7:0] RST_GRAY_LIMIT   = 8'd20;
	localparam logic [7:0] RST_YELLOW_START = 8'd35;
	localparam logic [7:0] RST_GREEN_START  = 8'd50;
	localparam logic [7:0] RST_GREEN_END    = 8'd90;
	localparam logic [7:0] RST_BLUE_START   = 8'd130;
	localparam logic [7:0] RST_BLUE_END     = 8'd180;

	localparam logic [7:0] HSL_MAX      = 8'd240;
	localparam logic [7:0] HALF_LIGHT   = 8'd120;
	localparam logic [7:0] HUE_RED_WRAP = 8'd220;
	localparam logic [7:0] HUE_BASE_RED  = 8'd0;
	localparam logic [7:0] HUE_BASE_GRN  = 8'd80;
	localparam logic [7:0] HUE_BASE_BLU  = 8'd160;
	localparam logic [7:0] HUE_BASE_WRAP = 8'd240;
	localparam logic [8:0] SUM_TOP      = 9'd510;
	// lightness = sum*240/510 = (sum*482) >> 10, exact for sum <= 510
	localparam logic [8:0] LIGHT_RECIP  = 9'd482;
	localparam int         LIGHT_SHIFT  = 10;

	typedef enum logic [2:0] {
		CLS_UNKNOWN = 3'd0,
		CLS_WHITE   = 3'd1,
		CLS_BLACK   = 3'd2,
		CLS_GRAY    = 3'd3,
		CLS_RED     = 3'd4,
		CLS_YELLOW  = 3'd5,
		CLS_GREEN   = 3'd6,
		CLS_BLUE    = 3'd7
	} color_class_t;

	typedef struct packed {
		logic [7:0] dark_limit;
		logic [7:0] bright_limit;
		logic [7:0] gray_limit;
		logic [7:0] yellow_start;
		logic [7:0] green_start;
		logic [7:0] green_end;
		logic [7:0] blue_start;
		logic [7:0] blue_end;
	} cfg_t;

	// first stage: extremes and hue sector
	typedef struct packed {
		logic [7:0] mx;
		logic [7:0] mn;
		logic [7:0] diff_mag;
		logic       neg;
		logic [7:0] base;
	} front_t;

	// carried through the divider stages
	typedef struct packed {
		logic [15:0] hue_rem;
		logic [15:0] hue_den;
		logic [7:0]  hue_q;
		logic [15:0] sat_rem;
		logic [15:0] sat_den;
		logic [7:0]  sat_q;
		logic        neg;
		logic [7:0]  base;
		logic        zero_h;
		logic        zero_s;
		logic [7:0]  light;
	} div_t;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] sat;
		logic [7:0] light;
	} hsl_t;

endpackage

/* src/rhcc_if.sv */
// ----------------------------------------------------------------------------
// rhcc_if
// Stream channels of the color classifier: pixels, results, configuration.
// ----------------------------------------------------------------------------
interface rhcc_pixel_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel;
	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface rhcc_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] color_class;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] lightness;
	modport source (output valid, output color_class, output hue, output saturation,
		output lightness, input ready);
	modport sink (input valid, input color_class, input hue, input saturation,
		input lightness, output ready);
endinterface

interface rhcc_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* src/rhcc_front.sv */
// ----------------------------------------------------------------------------
// rhcc_front
// Channel expansion, extremes, lightness and divider operands (two stages).
// ----------------------------------------------------------------------------
module rhcc_front (
	input  logic           clk,
	input  logic           en_s1,
	input  logic           en_s2,
	input  logic [15:0]    pixel,
	output rhcc_pkg::div_t div_s2
);

	logic [7:0] r8, g8, b8, mx, mn;
	rhcc_pkg::front_t front_c, front_s1;
	rhcc_pkg::div_t   div_c;
	logic [7:0]  d;
	logic [8:0]  sum, den;
	logic [17:0] light_prod;
	logic [7:0]  light;
	logic [15:0] hue_num, sat_num;

	always_comb begin
		r8 = {pixel[15:11], 3'b000};
		g8 = {pixel[10:5], 2'b00};
		b8 = {pixel[4:0], 3'b000};
		mx = r8;
		if (g8 > mx) mx = g8;
		if (b8 > mx) mx = b8;
		mn = r8;
		if (g8 < mn) mn = g8;
		if (b8 < mn) mn = b8;
		front_c.mx = mx;
		front_c.mn = mn;
		// sector order: red first, then green, then blue
		if (mx == r8) begin
			front_c.neg      = g8 < b8;
			front_c.diff_mag = (g8 >= b8) ? g8 - b8 : b8 - g8;
			front_c.base     = (g8 >= b8) ? rhcc_pkg::HUE_BASE_RED : rhcc_pkg::HUE_BASE_WRAP;
		end else if (mx == g8) begin
			front_c.neg      = b8 < r8;
			front_c.diff_mag = (b8 >= r8) ? b8 - r8 : r8 - b8;
			front_c.base     = rhcc_pkg::HUE_BASE_GRN;
		end else begin
			front_c.neg      = r8 < g8;
			front_c.diff_mag = (r8 >= g8) ? r8 - g8 : g8 - r8;
			front_c.base     = rhcc_pkg::HUE_BASE_BLU;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) front_s1 <= front_c;
	end

	always_comb begin
		d          = front_s1.mx - front_s1.mn;
		sum        = {1'b0, front_s1.mx} + {1'b0, front_s1.mn};
		light_prod = {9'd0, sum} * {9'd0, rhcc_pkg::LIGHT_RECIP};
		light      = light_prod[rhcc_pkg::LIGHT_SHIFT +: 8];
		// 40*x and 240*x as shift-adds
		hue_num    = {3'd0, front_s1.diff_mag, 5'd0} + {5'd0, front_s1.diff_mag, 3'd0};
		sat_num    = {d, 8'd0} - {4'd0, d, 4'd0};
		den        = (light <= rhcc_pkg::HALF_LIGHT) ? sum : rhcc_pkg::SUM_TOP - sum;
		div_c.hue_rem = hue_num;
		div_c.hue_den = {1'b0, d, 7'd0};
		div_c.hue_q   = 8'd0;
		div_c.sat_rem = sat_num;
		div_c.sat_den = {den, 7'd0};
		div_c.sat_q   = 8'd0;
		div_c.neg     = front_s1.neg;
		div_c.base    = front_s1.base;
		div_c.zero_h  = d == 8'd0;
		div_c.zero_s  = (d == 8'd0) || (light == 8'd0) || (den == 9'd0);
		div_c.light   = light;
	end

	always_ff @(posedge clk) begin
		if (en_s2) div_s2 <= div_c;
	end

endmodule

/* src/rhcc_div_stage.sv */
// ----------------------------------------------------------------------------
// rhcc_div_stage
// Two restoring division steps for the hue and saturation lanes.
// ----------------------------------------------------------------------------
module rhcc_div_stage (
	input  logic           clk,
	input  logic           en,
	input  rhcc_pkg::div_t div_in,
	output rhcc_pkg::div_t div_out
);

	rhcc_pkg::div_t cur;

	// divisor is kept pre-shifted and moves right one bit per quotient bit
	always_comb begin
		cur = div_in;
		for (int i = 0; i < 2; i++) begin
			if (cur.hue_rem >= cur.hue_den) begin
				cur.hue_rem = cur.hue_rem - cur.hue_den;
				cur.hue_q   = {cur.hue_q[6:0], 1'b1};
			end else begin
				cur.hue_q   = {cur.hue_q[6:0], 1'b0};
			end
			if (cur.sat_rem >= cur.sat_den) begin
				cur.sat_rem = cur.sat_rem - cur.sat_den;
				cur.sat_q   = {cur.sat_q[6:0], 1'b1};
			end else begin
				cur.sat_q   = {cur.sat_q[6:0], 1'b0};
			end
			cur.hue_den = {1'b0, cur.hue_den[15:1]};
			cur.sat_den = {1'b0, cur.sat_den[15:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) div_out <= cur;
	end

endmodule

/* src/rhcc_classify.sv */
// ----------------------------------------------------------------------------
// rhcc_classify
// Hue and saturation finish with clamping, then threshold classification.
// ----------------------------------------------------------------------------
module rhcc_classify (
	input  logic                 clk,
	input  logic                 en_s7,
	input  logic                 en_s8,
	input  rhcc_pkg::div_t       div_in,
	input  rhcc_pkg::cfg_t       cfg,
	output rhcc_pkg::hsl_t       hsl_s8,
	output rhcc_pkg::color_class_t class_s8
);

	rhcc_pkg::hsl_t hsl_c, hsl_s7;
	rhcc_pkg::color_class_t class_c;
	logic [8:0] hue_sum;

	always_comb begin
		hue_sum = {1'b0, div_in.base} + {1'b0, div_in.hue_q};
		if (div_in.zero_h) begin
			hsl_c.hue = 8'd0;
		end else if (div_in.neg) begin
			hsl_c.hue = (div_in.hue_q > div_in.base) ? 8'd0 : div_in.base - div_in.hue_q;
		end else begin
			hsl_c.hue = (hue_sum > {1'b0, rhcc_pkg::HSL_MAX}) ? rhcc_pkg::HSL_MAX
				: hue_sum[7:0];
		end
		if (div_in.zero_s) begin
			hsl_c.sat = 8'd0;
		end else begin
			hsl_c.sat = (div_in.sat_q > rhcc_pkg::HSL_MAX) ? rhcc_pkg::HSL_MAX : div_in.sat_q;
		end
		hsl_c.light = div_in.light;
	end

	always_ff @(posedge clk) begin
		if (en_s7) hsl_s7 <= hsl_c;
	end

	// hue bands: later bands override earlier ones
	always_comb begin
		class_c = rhcc_pkg::CLS_UNKNOWN;
		if (hsl_s7.light >= cfg.bright_limit) begin
			class_c = rhcc_pkg::CLS_WHITE;
		end else if (hsl_s7.light <= cfg.dark_limit) begin
			class_c = rhcc_pkg::CLS_BLACK;
		end else if (hsl_s7.sat <= cfg.gray_limit) begin
			class_c = rhcc_pkg::CLS_GRAY;
		end else begin
			if (hsl_s7.hue < cfg.yellow_start || hsl_s7.hue > rhcc_pkg::HUE_RED_WRAP)
				class_c = rhcc_pkg::CLS_RED;
			if (hsl_s7.hue >= cfg.yellow_start && hsl_s7.hue < cfg.green_start)
				class_c = rhcc_pkg::CLS_YELLOW;
			if (hsl_s7.hue >= cfg.green_start && hsl_s7.hue < cfg.green_end)
				class_c = rhcc_pkg::CLS_GREEN;
			if (hsl_s7.hue >= cfg.blue_start && hsl_s7.hue < cfg.blue_end)
				class_c = rhcc_pkg::CLS_BLUE;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			hsl_s8   <= hsl_s7;
			class_s8 <= class_c;
		end
	end

endmodule

/* src/rgb565_hsl_color_classifier_top.sv */
// ----------------------------------------------------------------------------
// rgb565_hsl_color_classifier_top
// RGB565 pixel to HSL conversion and color classification, fully pipelined.
// ----------------------------------------------------------------------------
// usage:
//   pixels  : valid/ready stream of 16-bit RGB565 pixels
//   results : valid/ready stream, one result per pixel, in pixel order:
//             color_class, hue, saturation, lightness (0..240 each)
//   cfg     : valid/ready write channel, index 0..7 selects one of the eight
//             thresholds; always ready, write only while the pipe is empty
// timing:
//   eight register stages from accept to result valid; throughput one
//   pixel per cycle unless a held result fills the pipe; the two divisions
//   run as restoring dividers over four stages at two quotient bits per stage
// reset:
//   arst_n clears all stage valid bits and loads the default thresholds
// stall:
//   each stage loads whenever it or any later stage has room, so a held
//   result only blocks input once every stage is occupied
// ----------------------------------------------------------------------------
module rgb565_hsl_color_classifier_top (
	input  logic         clk,
	input  logic         arst_n,
	rhcc_pixel_if.sink   pixels,
	rhcc_result_if.source results,
	rhcc_cfg_if.sink     cfg
);

	localparam int N = rhcc_pkg::NUM_STAGES;

	logic [N-1:0] valid_q;
	logic [N-1:0] load;
	rhcc_pkg::cfg_t cfg_q;
	rhcc_pkg::div_t div_s2, div_s3, div_s4, div_s5, div_s6;
	rhcc_pkg::hsl_t hsl_s8;
	rhcc_pkg::color_class_t class_s8;

	always_comb begin
		load[N-1] = !valid_q[N-1] || results.ready;
		for (int k = N - 2; k >= 0; k--) begin
			load[k] = !valid_q[k] || load[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0]) valid_q[0] <= pixels.valid;
			for (int k = 1; k < N; k++) begin
				if (load[k]) valid_q[k] <= valid_q[k-1];
			end
		end
	end

	assign pixels.ready = load[0];
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_limit   <= rhcc_pkg::RST_DARK_LIMIT;
			cfg_q.bright_limit <= rhcc_pkg::RST_BRIGHT_LIMIT;
			cfg_q.gray_limit   <= rhcc_pkg::RST_GRAY_LIMIT;
			cfg_q.yellow_start <= rhcc_pkg::RST_YELLOW_START;
			cfg_q.green_start  <= rhcc_pkg::RST_GREEN_START;
			cfg_q.green_end    <= rhcc_pkg::RST_GREEN_END;
			cfg_q.blue_start   <= rhcc_pkg::RST_BLUE_START;
			cfg_q.blue_end     <= rhcc_pkg::RST_BLUE_END;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rhcc_pkg::REG_DARK_LIMIT:   cfg_q.dark_limit   <= cfg.data;
				rhcc_pkg::REG_BRIGHT_LIMIT: cfg_q.bright_limit <= cfg.data;
				rhcc_pkg::REG_GRAY_LIMIT:   cfg_q.gray_limit   <= cfg.data;
				rhcc_pkg::REG_YELLOW_START: cfg_q.yellow_start <= cfg.data;
				rhcc_pkg::REG_GREEN_START:  cfg_q.green_start  <= cfg.data;
				rhcc_pkg::REG_GREEN_END:    cfg_q.green_end    <= cfg.data;
				rhcc_pkg::REG_BLUE_START:   cfg_q.blue_start   <= cfg.data;
				rhcc_pkg::REG_BLUE_END:     cfg_q.blue_end     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	rhcc_front u_front (
		.clk    (clk),
		.en_s1  (load[0]),
		.en_s2  (load[1]),
		.pixel  (pixels.pixel),
		.div_s2 (div_s2)
	);

	rhcc_div_stage u_div3 (.clk(clk), .en(load[2]), .div_in(div_s2), .div_out(div_s3));
	rhcc_div_stage u_div4 (.clk(clk), .en(load[3]), .div_in(div_s3), .div_out(div_s4));
	rhcc_div_stage u_div5 (.clk(clk), .en(load[4]), .div_in(div_s4), .div_out(div_s5));
	rhcc_div_stage u_div6 (.clk(clk), .en(load[5]), .div_in(div_s5), .div_out(div_s6));

	rhcc_classify u_classify (
		.clk      (clk),
		.en_s7    (load[6]),
		.en_s8    (load[7]),
		.div_in   (div_s6),
		.cfg      (cfg_q),
		.hsl_s8   (hsl_s8),
		.class_s8 (class_s8)
	);

	assign results.valid       = valid_q[N-1];
	assign results.color_class = class_s8;
	assign results.hue         = hsl_s8.hue;
	assign results.saturation  = hsl_s8.sat;
	assign results.lightness   = hsl_s8.light;

endmodule

/* src/rhcc_checker.sv */
// ----------------------------------------------------------------------------
// rhcc_checker
// Port-level checks of the color classifier, bound to the top level.
// ----------------------------------------------------------------------------
module rhcc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] out_class,
	input logic [7:0] out_hue,
	input logic [7:0] out_sat,
	input logic [7:0] out_light
);

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_class) && $stable(out_hue)
			&& $stable(out_sat) && $stable(out_light))
		else $error("result changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_hue <= 8'd240 && out_sat <= 8'd240 && out_light <= 8'd240)
		else $error("hsl value above 240");

	// zero saturation only comes from the gray axis, where hue is zero too
	a_gray_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_sat == 8'd0 |-> out_hue == 8'd0)
		else $error("zero saturation with nonzero hue");

	// input backpressure only when the pipe is full behind a stalled result
	a_no_idle_block: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked while output free");

endmodule

bind rgb565_hsl_color_classifier_top rhcc_checker u_rhcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pixels.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_class (results.color_class),
	.out_hue   (results.hue),
	.out_sat   (results.saturation),
	.out_light (results.lightness)
);
